[rtl/modexp_pkg.sv]
// Package for the modular exponentiation block: stream widths, the sequencer
// state type and the status struct of the bit-serial modular multiplier.
// No dependencies.
package modexp_pkg;

  localparam int unsigned BaseW   = 32;
  localparam int unsigned ExpW    = 64;
  localparam int unsigned ModW    = 32;
  localparam int unsigned ResultW = 32;
  localparam int unsigned InDataW = BaseW + ExpW + ModW;
  localparam int unsigned OutDataW = ResultW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } modexp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

[rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: stream ports, sequencer and
// result register. Depends on modexp_pkg and modexp_mulmod.
//
// Computes base_value to the power exponent modulo modulus by right-to-left
// square-and-multiply, one request at a time. All arithmetic goes through a
// single bit-serial modular multiplier that handles one multiplier bit per
// cycle, over NB = max(WIDTH, 32) bits per multiplication. The base is first
// reduced with one such pass; then each of the EXP_WIDTH exponent bits costs
// a decision step, one squaring and, for a one bit, one more multiplication.
// A zero modulus skips the arithmetic and is answered with the zero_modulus
// flag set. Only the low WIDTH bits of the modulus (at most 32) and the low
// EXP_WIDTH bits of the exponent are used. The result sits in an output
// register, and a new request is taken once the previous result has been
// handed to that register.
module modular_exponentiation import modexp_pkg::*; #(
  parameter int WIDTH     = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // base_value [31:0], exponent [95:32], modulus [127:96]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // power_result [31:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  // zero_modulus [0]
  output logic [0:0]          m_axis_tuser
);

  localparam int NbW  = (WIDTH > 32) ? WIDTH : 32;
  localparam int MW   = (WIDTH < 32) ? WIDTH : 32;
  localparam int ECntW = $clog2(EXP_WIDTH + 1);

  modexp_state_e        state_q, state_d;
  logic [WIDTH-1:0]     m_q, res_q, base_q;
  logic [EXP_WIDTH-1:0] e_q;
  logic [ECntW-1:0]     ecnt_q;
  logic                 err_q;
  logic                 out_valid_q;
  logic [ResultW-1:0]   out_data_q;
  logic                 out_err_q;

  logic                 in_fire;
  logic [WIDTH-1:0]     in_mod;
  logic [WIDTH-1:0]     one_mod;
  logic                 out_free;
  logic                 mm_start;
  logic [WIDTH-1:0]     mm_a, mm_b;
  logic [WIDTH-1:0]     mm_m;
  logic [NbW-1:0]       mm_b_wide;
  mm_status_t           mm_stat;
  logic [WIDTH-1:0]     mm_prod;

  assign in_mod   = WIDTH'(s_axis_tdata[BaseW+ExpW +: MW]);
  assign one_mod  = (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign mm_m     = (state_q == ST_IDLE) ? in_mod : m_q;

  always_comb begin
    state_d   = state_q;
    mm_start  = 1'b0;
    mm_a      = base_q;
    mm_b      = base_q;
    mm_b_wide = NbW'(mm_b);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mod == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d   = ST_REDUCE;
            mm_start  = 1'b1;
            mm_a      = one_mod;
            mm_b_wide = NbW'(s_axis_tdata[BaseW-1:0]);
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (ecnt_q == '0) begin
          state_d = ST_DONE;
        end else if (e_q[0]) begin
          state_d   = ST_MUL;
          mm_start  = 1'b1;
          mm_a      = res_q;
          mm_b_wide = NbW'(base_q);
        end else begin
          state_d  = ST_SQR;
          mm_start = 1'b1;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          state_d  = ST_SQR;
          mm_start = 1'b1;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        m_q    <= in_mod;
        e_q    <= s_axis_tdata[BaseW +: EXP_WIDTH];
        ecnt_q <= ECntW'(EXP_WIDTH);
        res_q  <= one_mod;
        err_q  <= (in_mod == '0);
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_q <= mm_prod;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          res_q <= mm_prod;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          base_q <= mm_prod;
          e_q    <= e_q >> 1;
          ecnt_q <= ecnt_q - ECntW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= err_q ? '0 : ResultW'(res_q);
          out_err_q  <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

  modexp_mulmod #(
    .WIDTH    (WIDTH),
    .NB_WIDTH (NbW)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (mm_a),
    .b_i      (mm_b_wide),
    .m_i      (mm_m),
    .status_o (mm_stat),
    .prod_o   (mm_prod)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_err_q;

  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_stat.done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
    else $error("Multiplier finished outside a multiplication state.");

  a_operands_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (res_q < m_q && base_q < m_q))
    else $error("Running values not reduced below the modulus.");

  a_error_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("Zero modulus result is not zero.");

  a_request_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("Accepted request did not start the sequencer.");

endmodule

[rtl/modexp_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on modexp_pkg for the status struct.
module modexp_mulmod import modexp_pkg::*; #(
  parameter int WIDTH    = 32,
  parameter int NB_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [NB_WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0]    m_i,
  output mm_status_t          status_o,
  output logic [WIDTH-1:0]    prod_o
);

  localparam int CntW = $clog2(NB_WIDTH + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WIDTH-1:0]    acc_q, acc_d;
  logic [WIDTH-1:0]    a_q, a_d;
  logic [WIDTH-1:0]    m_q, m_d;
  logic [NB_WIDTH-1:0] b_q, b_d;
  logic [WIDTH+1:0]    sum, m1, m2;

  always_comb begin
    m1 = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (b_q[NB_WIDTH-1] ? {2'b00, a_q} : '0);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    m_d    = m_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NB_WIDTH);
      acc_d  = '0;
      a_d    = a_i;
      m_d    = m_i;
      b_d    = b_i;
    end else if (busy_q) begin
      // The doubled accumulator plus the addend stays below three times the modulus.
      if (sum >= m2) begin
        acc_d = WIDTH'(sum - m2);
      end else if (sum >= m1) begin
        acc_d = WIDTH'(sum - m1);
      end else begin
        acc_d = WIDTH'(sum);
      end
      b_d   = {b_q[NB_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    m_q   <= m_d;
    b_q   <= b_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("Multiplier started while busy.");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_q < m_q)
    else $error("Accumulator not reduced below the modulus.");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("Done flagged without a finished multiplication.");

endmodule
